// ===== sv/assert_macros.svh =====
// Assertion macros used by the RTL digest engine.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/sha1md_pkg.sv =====
// Package: types, constants and round functions for the SHA-1 digest block.
`timescale 1ns / 1ps

package sha1md_pkg;

   localparam int WORD_W  = 32;
   localparam int NWORDS  = 5;
   localparam int BYTE_W  = 8;
   localparam int BLK_W   = 512;
   localparam int LEN_W   = 64;
   localparam int FILL_W  = 6;
   localparam int ROUND_W = 7;

   localparam logic CMD_ABSORB = 1'b0;
   localparam logic CMD_FINISH = 1'b1;

   localparam logic [BYTE_W-1:0]  PAD_MARK   = 8'h80;
   localparam logic [FILL_W-1:0]  FILL_LAST  = 6'd63;
   localparam logic [ROUND_W-1:0] ROUND_LAST = 7'd79;

   localparam logic [WORD_W-1:0] K0 = 32'h5A827999;
   localparam logic [WORD_W-1:0] K1 = 32'h6ED9EBA1;
   localparam logic [WORD_W-1:0] K2 = 32'h8F1BBCDC;
   localparam logic [WORD_W-1:0] K3 = 32'hCA62C1D6;

   typedef logic [NWORDS-1:0][WORD_W-1:0] words_type;

   localparam words_type INIT_WORDS = {
      32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
   };

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PAD,
      ST_ROUND,
      ST_FINAL
   } state_type;

   function automatic logic [WORD_W-1:0] round_f(input logic [ROUND_W-1:0] rnd,
                                                 input logic [WORD_W-1:0] b,
                                                 input logic [WORD_W-1:0] c,
                                                 input logic [WORD_W-1:0] d);
      logic [WORD_W-1:0] f;
      if (rnd < 7'd20) begin
         f = (b & c) | (~b & d);
      end else if (rnd < 7'd40) begin
         f = b ^ c ^ d;
      end else if (rnd < 7'd60) begin
         f = (b & c) | (b & d) | (c & d);
      end else begin
         f = b ^ c ^ d;
      end
      return f;
   endfunction

   function automatic logic [WORD_W-1:0] round_k(input logic [ROUND_W-1:0] rnd);
      logic [WORD_W-1:0] k;
      if (rnd < 7'd20) begin
         k = K0;
      end else if (rnd < 7'd40) begin
         k = K1;
      end else if (rnd < 7'd60) begin
         k = K2;
      end else begin
         k = K3;
      end
      return k;
   endfunction

endpackage

// ===== sv/sha1md_if.sv =====
// Channel interfaces: request (command and byte) and response (digest words).
`timescale 1ns / 1ps

interface sha1md_req_if;
   logic                            valid;
   logic                            ready;
   logic                            cmd;
   logic [sha1md_pkg::BYTE_W-1:0]   data_byte;

   modport source (output valid, output cmd, output data_byte, input ready);
   modport sink   (input valid, input cmd, input data_byte, output ready);
endinterface

interface sha1md_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [sha1md_pkg::WORD_W-1:0]   digest_word0;
   logic [sha1md_pkg::WORD_W-1:0]   digest_word1;
   logic [sha1md_pkg::WORD_W-1:0]   digest_word2;
   logic [sha1md_pkg::WORD_W-1:0]   digest_word3;
   logic [sha1md_pkg::WORD_W-1:0]   digest_word4;

   modport source (output valid, output digest_word0, output digest_word1,
                   output digest_word2, output digest_word3, output digest_word4,
                   input ready);
   modport sink   (input valid, input digest_word0, input digest_word1,
                   input digest_word2, input digest_word3, input digest_word4,
                   output ready);
endinterface

// ===== sv/sha1_message_digest.sv =====
// SHA-1 digest engine: byte absorb, padding sequencer, shared round unit.
//
// channel   dir  transaction
// req_bus   in   cmd (absorb/finish), data_byte
// rsp_bus   out  digest_word0..digest_word4, one per finish
//
// Absorb shifts a byte into the block; the 64th byte of a block starts the
// passes through the single round adder, then the chaining add.
// Finish shifts padding in at one byte per cycle up to the block end, then
// compresses; a block with under 9 bytes of room costs a second block.
// Synchronous active-high reset loads the initial chaining words.
// A held response stalls the next digest, and all input while that digest waits.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module sha1_message_digest (
   input  logic             clock,
   input  logic             reset,
   sha1md_req_if.sink       req_bus,
   sha1md_rsp_if.source     rsp_bus
);

   sha1md_pkg::state_type                 state_ff, state_in;
   logic [sha1md_pkg::FILL_W-1:0]         fill_ff, fill_in;
   logic [sha1md_pkg::LEN_W-1:0]          bitlen_ff, bitlen_in;
   logic [sha1md_pkg::BLK_W-1:0]          blk_ff, blk_in;
   sha1md_pkg::words_type                 chain_ff, chain_in;
   sha1md_pkg::words_type                 wk_ff, wk_in;
   sha1md_pkg::words_type                 dig_ff, dig_in;
   logic [sha1md_pkg::ROUND_W-1:0]        round_ff, round_in;
   logic                                  pad_ff, pad_in;
   logic                                  mark_ff, mark_in;
   logic                                  room_ff, room_in;
   logic                                  last_ff, last_in;
   logic                                  rsp_valid_ff, rsp_valid_in;

   logic                                  accept;
   logic                                  absorb;
   logic                                  finish;
   logic                                  byte_en;
   logic [sha1md_pkg::BYTE_W-1:0]         byte_val;
   logic                                  len_shift;
   logic                                  load_work;
   logic                                  round_step;
   logic                                  finish_add;
   logic                                  emit;
   logic                                  out_busy;
   logic                                  len_zone;

   logic [sha1md_pkg::WORD_W-1:0]         w0, w2, w8, w13, wx, wnew, tmp;
   sha1md_pkg::words_type                 sum;

   assign accept   = req_bus.valid && req_bus.ready;
   assign absorb   = accept && (req_bus.cmd == sha1md_pkg::CMD_ABSORB);
   assign finish   = accept && (req_bus.cmd == sha1md_pkg::CMD_FINISH);
   assign out_busy = rsp_valid_ff && !rsp_bus.ready;
   assign len_zone = (fill_ff[5:3] == 3'b111);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sha1md_pkg::ST_IDLE: begin
            if (finish) begin
               state_in = sha1md_pkg::ST_PAD;
            end else if (absorb && fill_ff == sha1md_pkg::FILL_LAST) begin
               state_in = sha1md_pkg::ST_ROUND;
            end
         end
         sha1md_pkg::ST_PAD: begin
            if (fill_ff == sha1md_pkg::FILL_LAST) begin
               state_in = sha1md_pkg::ST_ROUND;
            end
         end
         sha1md_pkg::ST_ROUND: begin
            if (round_ff == sha1md_pkg::ROUND_LAST) begin
               state_in = sha1md_pkg::ST_FINAL;
            end
         end
         sha1md_pkg::ST_FINAL: begin
            if (last_ff && out_busy) begin
               state_in = sha1md_pkg::ST_FINAL;
            end else if (pad_ff && !last_ff) begin
               state_in = sha1md_pkg::ST_PAD;
            end else begin
               state_in = sha1md_pkg::ST_IDLE;
            end
         end
         default: state_in = sha1md_pkg::ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      req_bus.ready = 1'b0;
      byte_en       = 1'b0;
      byte_val      = req_bus.data_byte;
      len_shift     = 1'b0;
      round_step    = 1'b0;
      finish_add    = 1'b0;
      case (state_ff)
         sha1md_pkg::ST_IDLE: begin
            req_bus.ready = 1'b1;
            byte_en       = absorb;
         end
         sha1md_pkg::ST_PAD: begin
            byte_en = 1'b1;
            if (mark_ff) begin
               byte_val = sha1md_pkg::PAD_MARK;
            end else if (room_ff && len_zone) begin
               byte_val  = bitlen_ff[63:56];
               len_shift = 1'b1;
            end else begin
               byte_val = '0;
            end
         end
         sha1md_pkg::ST_ROUND: begin
            round_step = 1'b1;
         end
         sha1md_pkg::ST_FINAL: begin
            finish_add = !(last_ff && out_busy);
         end
         default: begin
            req_bus.ready = 1'b0;
         end
      endcase
   end

   assign load_work = byte_en && (fill_ff == sha1md_pkg::FILL_LAST);
   assign emit      = finish_add && last_ff;

   // schedule and round unit
   assign w0   = blk_ff[511:480];
   assign w2   = blk_ff[447:416];
   assign w8   = blk_ff[255:224];
   assign w13  = blk_ff[95:64];
   assign wx   = w13 ^ w8 ^ w2 ^ w0;
   assign wnew = {wx[30:0], wx[31]};
   assign tmp  = {wk_ff[0][26:0], wk_ff[0][31:27]}
               + sha1md_pkg::round_f(round_ff, wk_ff[1], wk_ff[2], wk_ff[3])
               + wk_ff[4] + sha1md_pkg::round_k(round_ff) + w0;

   always_comb begin
      for (int i = 0; i < sha1md_pkg::NWORDS; i++) begin
         sum[i] = chain_ff[i] + wk_ff[i];
      end
   end

   // datapath next values
   always_comb begin
      fill_in      = fill_ff;
      bitlen_in    = bitlen_ff;
      blk_in       = blk_ff;
      chain_in     = chain_ff;
      wk_in        = wk_ff;
      dig_in       = dig_ff;
      round_in     = round_ff;
      pad_in       = pad_ff;
      mark_in      = mark_ff;
      room_in      = room_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_bus.ready ? 1'b0 : rsp_valid_ff;

      if (finish) begin
         pad_in  = 1'b1;
         mark_in = 1'b1;
         room_in = !len_zone;
         last_in = 1'b0;
      end
      if (byte_en) begin
         fill_in = fill_ff + 6'd1;
         blk_in  = {blk_ff[sha1md_pkg::BLK_W-sha1md_pkg::BYTE_W-1:0], byte_val};
         if (state_ff == sha1md_pkg::ST_PAD) begin
            mark_in = 1'b0;
            if (room_ff && fill_ff == sha1md_pkg::FILL_LAST) begin
               last_in = 1'b1;
            end
         end
      end
      if (absorb) begin
         bitlen_in = bitlen_ff + 64'd8;
      end
      if (len_shift) begin
         bitlen_in = {bitlen_ff[55:0], 8'h00};
      end
      if (load_work) begin
         wk_in    = chain_ff;
         round_in = '0;
      end
      if (round_step) begin
         blk_in   = {blk_ff[sha1md_pkg::BLK_W-sha1md_pkg::WORD_W-1:0], wnew};
         wk_in[0] = tmp;
         wk_in[1] = wk_ff[0];
         wk_in[2] = {wk_ff[1][1:0], wk_ff[1][31:2]};
         wk_in[3] = wk_ff[2];
         wk_in[4] = wk_ff[3];
         round_in = round_ff + 7'd1;
      end
      if (finish_add) begin
         chain_in = sum;
         if (pad_ff && !last_ff) begin
            room_in = 1'b1;
         end
      end
      if (emit) begin
         dig_in       = sum;
         chain_in     = sha1md_pkg::INIT_WORDS;
         fill_in      = '0;
         bitlen_in    = '0;
         pad_in       = 1'b0;
         last_in      = 1'b0;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sha1md_pkg::ST_IDLE;
         fill_ff      <= '0;
         bitlen_ff    <= '0;
         chain_ff     <= sha1md_pkg::INIT_WORDS;
         round_ff     <= '0;
         pad_ff       <= 1'b0;
         mark_ff      <= 1'b0;
         room_ff      <= 1'b0;
         last_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         bitlen_ff    <= bitlen_in;
         chain_ff     <= chain_in;
         round_ff     <= round_in;
         pad_ff       <= pad_in;
         mark_ff      <= mark_in;
         room_ff      <= room_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      blk_ff <= blk_in;
      wk_ff  <= wk_in;
      dig_ff <= dig_in;
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.digest_word0 = dig_ff[0];
   assign rsp_bus.digest_word1 = dig_ff[1];
   assign rsp_bus.digest_word2 = dig_ff[2];
   assign rsp_bus.digest_word3 = dig_ff[3];
   assign rsp_bus.digest_word4 = dig_ff[4];

   `ASSERT_NEXT(a_full_block_starts, clock, reset, load_work, (state_ff == sha1md_pkg::ST_ROUND) && (round_ff == 7'd0), "full block did not start the rounds")
   `ASSERT_NEXT(a_rounds_end, clock, reset, (state_ff == sha1md_pkg::ST_ROUND) && (round_ff == sha1md_pkg::ROUND_LAST), state_ff == sha1md_pkg::ST_FINAL, "rounds did not end after the last pass")
   `ASSERT_NEXT(a_emit_restart, clock, reset, emit, rsp_valid_ff && (fill_ff == 6'd0) && (bitlen_ff == 64'd0) && !pad_ff, "digest emit did not restart the message")

endmodule

// ===== tb/sha1_message_digest_test.sv =====
// Testbench for sha1_message_digest: directed and random messages checked against a SHA-1 model.
`timescale 1ns / 1ps

module sha1_message_digest_test;

   localparam int IDLE_PCT      = 38;
   localparam int ITEM_TARGET   = 1850;
   localparam int RANDOM_ITEMS  = 1250;
   localparam int STEADY_ITEMS  = 300;
   localparam int HOLD_CYCLES   = 700;
   localparam int SETTLE_CYCLES = 300;

   localparam logic [159:0] SHA1_IV = {
      32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
   };
   localparam logic [31:0] RK_00 = 32'h5A827999;
   localparam logic [31:0] RK_20 = 32'h6ED9EBA1;
   localparam logic [31:0] RK_40 = 32'h8F1BBCDC;
   localparam logic [31:0] RK_60 = 32'hCA62C1D6;
   localparam logic [7:0]  PAD_BYTE = 8'h80;

   typedef struct packed {
      logic [31:0] word0;
      logic [31:0] word1;
      logic [31:0] word2;
      logic [31:0] word3;
      logic [31:0] word4;
   } digest_type;

   logic clock = 1'b0;
   logic reset;

   sha1md_req_if req_bus ();
   sha1md_rsp_if rsp_bus ();

   sha1_message_digest u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // running hash of the message in flight
   logic [31:0] hash_words [5];
   logic [7:0]  block_buf [64];
   int unsigned block_fill;
   logic [63:0] message_bits;

   digest_type expected_digests [$];
   int error_count = 0;
   int items_sent = 0;
   bit steady_flow = 1'b0;
   int hold_left = 0;

   always #1 clock = ~clock;

   function automatic logic [31:0] rotate_left(input logic [31:0] v, input int s);
      return (v << s) | (v >> (32 - s));
   endfunction

   function automatic void restart_digest();
      int i;
      for (i = 0; i < 5; i++) hash_words[i] = SHA1_IV[159 - 32 * i -: 32];
      block_fill = 0;
      message_bits = 64'd0;
   endfunction

   function automatic void hash_block();
      logic [31:0] w [80];
      logic [31:0] a, b, c, d, e, f, k, t;
      int r;
      for (r = 0; r < 16; r++) begin
         w[r] = {block_buf[4 * r], block_buf[4 * r + 1], block_buf[4 * r + 2],
                 block_buf[4 * r + 3]};
      end
      for (r = 16; r < 80; r++) begin
         w[r] = rotate_left(w[r - 3] ^ w[r - 8] ^ w[r - 14] ^ w[r - 16], 1);
      end
      a = hash_words[0];
      b = hash_words[1];
      c = hash_words[2];
      d = hash_words[3];
      e = hash_words[4];
      for (r = 0; r < 80; r++) begin
         if (r < 20) begin
            f = (b & c) | (~b & d);
            k = RK_00;
         end else if (r < 40) begin
            f = b ^ c ^ d;
            k = RK_20;
         end else if (r < 60) begin
            f = (b & c) | (b & d) | (c & d);
            k = RK_40;
         end else begin
            f = b ^ c ^ d;
            k = RK_60;
         end
         t = rotate_left(a, 5) + f + e + k + w[r];
         e = d;
         d = c;
         c = rotate_left(b, 30);
         b = a;
         a = t;
      end
      hash_words[0] += a;
      hash_words[1] += b;
      hash_words[2] += c;
      hash_words[3] += d;
      hash_words[4] += e;
   endfunction

   function automatic void absorb_byte(input logic [7:0] data);
      block_buf[block_fill] = data;
      block_fill++;
      message_bits += 64'd8;
      if (block_fill == 64) begin
         hash_block();
         block_fill = 0;
      end
   endfunction

   function automatic digest_type finish_message();
      digest_type result;
      int i;
      block_buf[block_fill] = PAD_BYTE;
      block_fill++;
      // no room left for the length field: pad out and spend an extra block
      if (block_fill > 56) begin
         while (block_fill < 64) begin
            block_buf[block_fill] = 8'h00;
            block_fill++;
         end
         hash_block();
         block_fill = 0;
      end
      while (block_fill < 56) begin
         block_buf[block_fill] = 8'h00;
         block_fill++;
      end
      for (i = 0; i < 8; i++) block_buf[56 + i] = message_bits[63 - 8 * i -: 8];
      hash_block();
      result = {hash_words[0], hash_words[1], hash_words[2], hash_words[3], hash_words[4]};
      restart_digest();
      return result;
   endfunction

   function automatic int pick_message_length();
      int sel;
      sel = $urandom_range(19);
      if (sel < 4) return $urandom_range(3);
      if (sel < 12) return $urandom_range(50, 4);
      if (sel < 17) return $urandom_range(68, 52);
      if (sel < 19) return $urandom_range(132, 116);
      return 64 * $urandom_range(4, 1);
   endfunction

   // Called and returns at a falling edge; valid stays high on return.
   task automatic send_item(input logic cmd, input logic [7:0] data);
      while (!steady_flow && $urandom_range(99) < IDLE_PCT) begin
         req_bus.valid     <= 1'b0;
         req_bus.cmd       <= 1'($urandom_range(1));
         req_bus.data_byte <= 8'($urandom_range(255));
         @(negedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.cmd       <= cmd;
      req_bus.data_byte <= data;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      if (cmd == sha1md_pkg::CMD_ABSORB) begin
         absorb_byte(data);
      end else begin
         expected_digests.push_back(finish_message());
      end
      items_sent++;
      @(negedge clock);
   endtask

   task automatic send_message(input int len);
      logic [7:0] data;
      int pattern;
      int i;
      pattern = $urandom_range(7);
      for (i = 0; i < len; i++) begin
         case (pattern)
            0: data = 8'h00;
            1: data = 8'hFF;
            default: data = 8'($urandom_range(255));
         endcase
         send_item(sha1md_pkg::CMD_ABSORB, data);
      end
      send_item(sha1md_pkg::CMD_FINISH, 8'($urandom_range(255)));
   endtask

   task automatic wait_for_digests();
      req_bus.valid <= 1'b0;
      do @(negedge clock); while (expected_digests.size() != 0);
   endtask

   task automatic test_directed();
      send_item(sha1md_pkg::CMD_FINISH, 8'h00);
      send_item(sha1md_pkg::CMD_FINISH, 8'hFF);
      send_item(sha1md_pkg::CMD_ABSORB, 8'h61);
      send_item(sha1md_pkg::CMD_ABSORB, 8'h62);
      send_item(sha1md_pkg::CMD_ABSORB, 8'h63);
      send_item(sha1md_pkg::CMD_FINISH, 8'h00);
      send_item(sha1md_pkg::CMD_ABSORB, 8'h00);
      send_item(sha1md_pkg::CMD_FINISH, 8'hFF);
      send_item(sha1md_pkg::CMD_ABSORB, 8'hFF);
      send_item(sha1md_pkg::CMD_FINISH, 8'h80);
      send_item(sha1md_pkg::CMD_ABSORB, 8'h55);
      send_item(sha1md_pkg::CMD_ABSORB, 8'hAA);
      send_item(sha1md_pkg::CMD_FINISH, 8'h7F);
      wait_for_digests();
   endtask

   task automatic test_random_messages(input int item_goal, input int min_messages);
      int count;
      count = 0;
      while (items_sent < item_goal || count < min_messages) begin
         send_message(pick_message_length());
         count++;
      end
   endtask

   task automatic test_steady_stream();
      int goal;
      goal = items_sent + STEADY_ITEMS;
      steady_flow = 1'b1;
      while (items_sent < goal) send_message(pick_message_length());
      wait_for_digests();
      steady_flow = 1'b0;
   endtask

   task automatic test_output_stall();
      int i;
      hold_left = HOLD_CYCLES;
      for (i = 0; i < 6; i++) send_message($urandom_range(20));
      wait_for_digests();
   endtask

   always @(posedge clock) begin
      if (hold_left > 0) hold_left <= hold_left - 1;
   end

   always @(negedge clock) begin
      rsp_bus.ready <= (hold_left == 0) && (steady_flow || $urandom_range(99) >= IDLE_PCT);
   end

   always @(posedge clock) begin : digest_check
      digest_type want;
      logic [31:0] got_words [5];
      logic [31:0] want_words [5];
      int i;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_digests.size() == 0) begin
            $error("unexpected digest transaction: %h %h %h %h %h",
                   rsp_bus.digest_word0, rsp_bus.digest_word1, rsp_bus.digest_word2,
                   rsp_bus.digest_word3, rsp_bus.digest_word4);
            error_count++;
         end else begin
            want = expected_digests.pop_front();
            got_words = '{rsp_bus.digest_word0, rsp_bus.digest_word1, rsp_bus.digest_word2,
                          rsp_bus.digest_word3, rsp_bus.digest_word4};
            want_words = '{want.word0, want.word1, want.word2, want.word3, want.word4};
            for (i = 0; i < 5; i++) begin
               if (got_words[i] !== want_words[i]) begin
                  $error("digest_word%0d: expected %h, actual %h", i, want_words[i],
                         got_words[i]);
                  error_count++;
               end
            end
         end
      end
   end

   initial begin
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.cmd = sha1md_pkg::CMD_ABSORB;
      req_bus.data_byte = 8'h00;
      rsp_bus.ready = 1'b0;
      restart_digest();
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_random_messages(RANDOM_ITEMS, 30);
      test_steady_stream();
      test_output_stall();
      test_random_messages(ITEM_TARGET, 4);

      wait_for_digests();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (error_count == 0) begin
         $display("sha1_message_digest_test passed");
      end else begin
         $display("sha1_message_digest_test failed");
      end
      $finish;
   end

   initial begin
      #5000000;
      $display("sha1_message_digest_test failed");
      $finish;
   end

endmodule
